// ===== rtl/core/aspl_pkg.sv =====
// ----------------------------------------------------------------------------
// aspl_pkg: shared types and constants of the allpass shelving low-pass filter
// Holds the field widths, the register indexes, the reset values of alpha
// and the shelf gain, the sequencer states and the datapath control word.
// ----------------------------------------------------------------------------
package aspl_pkg;

   localparam int FIELD_W    = 32;
   localparam int COEF_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CNT_W      = $clog2(COEF_W);

   localparam logic [CSR_INDEX_W-1:0] REG_ALLPASS_COEF = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHELF_GAIN   = 1'b1;

   localparam logic [COEF_W-1:0] ALLPASS_COEF_RESET = 32'd0;
   localparam logic [COEF_W-1:0] SHELF_GAIN_RESET   = 32'd322122547;

   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(COEF_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_AP_SAT,
      ST_MUL_K,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic start;
      logic step0;
      logic step1;
      logic ap_load;
      logic rsp_load;
   } ctrl_type;

endpackage

// ===== rtl/core/aspl_ifs.sv =====
// ----------------------------------------------------------------------------
// aspl_ifs: request and response channels of the filter
// Each channel carries valid, ready and its payload; a request moves when
// valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface aspl_req_if;
   import aspl_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface aspl_rsp_if;
   import aspl_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] sample_out;
   logic               clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== rtl/core/allpass_shelving_lowpass_top.sv =====
// ----------------------------------------------------------------------------
// allpass_shelving_lowpass_top: first-order allpass shelving low-pass filter
// One signed sample goes in on req and one filtered sample with a clip flag
// comes out on rsp. Alpha and the shelf gain are set through the csr port.
//
// A request is taken only while the sequencer is idle. The three products run
// on bit-serial shift-add lanes, one coefficient bit per cycle: alpha*x and
// alpha*ap_prev side by side in ST_MUL_A, then ST_AP_SAT forms and saturates
// the allpass output, then k*(x-ap) in ST_MUL_K, and ST_FIN rounds, saturates
// and loads the response register. The sequencer then returns to idle, where
// the next request can be accepted; a new request is not taken before the
// last one has been loaded into the response register.
// The response register parts the two sides: a finished result waits there
// while the next request is accepted and processed. If the receiver stalls,
// the sequencer holds its finished result until the response register frees.
// Synchronous reset clears both stored samples to zero, sets alpha to zero
// and the shelf gain to about 1.2, and empties the response register.
// ----------------------------------------------------------------------------
module allpass_shelving_lowpass_top #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   aspl_req_if.sink                          req,
   aspl_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [aspl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [aspl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import aspl_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int MW = SB + 1;
   localparam int HW = MW + 1;
   localparam int AW = HW + 1;
   localparam int YW = HW + 4;

   localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [COEF_W-1:0]  alpha_ff, gain_ff;
   logic [COEF_W-1:0]  coef_sh_ff, coef_sh_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MW-1:0]      m0_ff, m1_ff;
   logic [HW-1:0]      hi0_ff, hi1_ff;
   logic [COEF_W-1:0]  lo0_ff, lo1_ff;
   logic [SB-1:0]      x_ff, prev_x_ff, prev_ap_ff;
   logic [MW-1:0]      sum_ff;
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_clip_ff;

   logic               coef_bit, last_step;
   logic [HW-1:0]      m0_ext, m1_ext, add0, add1, s0, s1;
   logic [AW-1:0]      p1, p2, ap_raw;
   logic               ap_ovf;
   logic [SB-1:0]      ap_sat, x_new;
   logic [YW-1:0]      y_acc, y_sum;
   logic [YW-2:0]      y_wide;
   logic               y_ovf;
   logic signed [SB-1:0] y_sat;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            if (last_step) state_in = ST_AP_SAT;
         end
         ST_AP_SAT: state_in = ST_MUL_K;
         ST_MUL_K: begin
            if (last_step) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.start     = req.valid;
         end
         ST_MUL_A: begin
            ctrl.step0 = 1'b1;
            ctrl.step1 = 1'b1;
         end
         ST_AP_SAT: ctrl.ap_load = 1'b1;
         ST_MUL_K:  ctrl.step0   = 1'b1;
         ST_FIN:    ctrl.rsp_load = !rsp_valid_ff || rsp.ready;
         default:   ctrl = '0;
      endcase
   end

   assign req.ready = ctrl.req_ready;

   // Shift-add lanes; the last coefficient bit carries negative weight.
   assign coef_bit  = coef_sh_ff[0];
   assign last_step = (cnt_ff == STEP_LAST);
   assign m0_ext    = {m0_ff[MW-1], m0_ff};
   assign m1_ext    = {m1_ff[MW-1], m1_ff};
   assign add0 = coef_bit ? (last_step ? ({HW{1'b0}} - m0_ext) : m0_ext) : {HW{1'b0}};
   assign add1 = coef_bit ? (last_step ? ({HW{1'b0}} - m1_ext) : m1_ext) : {HW{1'b0}};
   assign s0   = hi0_ff + add0;
   assign s1   = hi1_ff + add1;

   assign coef_sh_in = {1'b0, coef_sh_ff[COEF_W-1:1]};
   assign cnt_in     = cnt_ff + CNT_W'(1);

   // Allpass output: floor(a*x/2^31) + floor(a*ap_prev/2^31) - x_prev.
   assign p1     = {hi0_ff, lo0_ff[COEF_W-1]};
   assign p2     = {hi1_ff, lo1_ff[COEF_W-1]};
   assign ap_raw = p1 + p2 - {{(AW-SB){prev_x_ff[SB-1]}}, prev_x_ff};
   assign ap_ovf = (ap_raw[AW-1:SB-1] != {(AW-SB+1){ap_raw[SB-1]}});
   assign ap_sat = ap_ovf ? (ap_raw[AW-1] ? SMIN : SMAX) : ap_raw[SB-1:0];

   // Output: (floor(k*diff/2^28) + sum) / 2, rounded toward minus infinity.
   assign y_acc  = {hi0_ff, lo0_ff[COEF_W-1:COEF_W-4]};
   assign y_sum  = y_acc + {{(YW-MW){sum_ff[MW-1]}}, sum_ff};
   assign y_wide = y_sum[YW-1:1];
   assign y_ovf  = (y_wide[YW-2:SB-1] != {(YW-SB){y_wide[SB-1]}});
   assign y_sat  = y_ovf ? (y_wide[YW-2] ? SMIN : SMAX) : y_wide[SB-1:0];
   assign rsp_sample_in = FIELD_W'(y_sat);

   assign x_new = req.sample_in[SB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         alpha_ff     <= ALLPASS_COEF_RESET;
         gain_ff      <= SHELF_GAIN_RESET;
         prev_x_ff    <= '0;
         prev_ap_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctrl.start || ctrl.ap_load) begin
            cnt_ff <= '0;
         end else if (ctrl.step0) begin
            cnt_ff <= cnt_in;
         end
         if (csr_we) begin
            case (csr_index)
               REG_ALLPASS_COEF: alpha_ff <= csr_wdata[COEF_W-1:0];
               REG_SHELF_GAIN:   gain_ff  <= csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end
         if (ctrl.ap_load) begin
            prev_x_ff  <= x_ff;
            prev_ap_ff <= ap_sat;
         end
         if (ctrl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         x_ff       <= x_new;
         m0_ff      <= {x_new[SB-1], x_new};
         m1_ff      <= {prev_ap_ff[SB-1], prev_ap_ff};
         coef_sh_ff <= alpha_ff;
         hi0_ff     <= '0;
         lo0_ff     <= '0;
         hi1_ff     <= '0;
         lo1_ff     <= '0;
      end else if (ctrl.ap_load) begin
         m0_ff      <= {x_ff[SB-1], x_ff} - {ap_sat[SB-1], ap_sat};
         sum_ff     <= {x_ff[SB-1], x_ff} + {ap_sat[SB-1], ap_sat};
         coef_sh_ff <= gain_ff;
         hi0_ff     <= '0;
         lo0_ff     <= '0;
      end else begin
         if (ctrl.step0) begin
            hi0_ff     <= {s0[HW-1], s0[HW-1:1]};
            lo0_ff     <= {s0[0], lo0_ff[COEF_W-1:1]};
            coef_sh_ff <= coef_sh_in;
         end
         if (ctrl.step1) begin
            hi1_ff <= {s1[HW-1], s1[HW-1:1]};
            lo1_ff <= {s1[0], lo1_ff[COEF_W-1:1]};
         end
      end
      if (ctrl.rsp_load) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_clip_ff   <= y_ovf;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.clipped    = rsp_clip_ff;

`ifndef SYNTHESIS
   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff == '0))
      else $error("step counter not cleared while idle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_MUL_A))
      else $error("accepted request did not start the allpass products");

   a_products_then_ap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_A && cnt_ff == STEP_LAST) |=> (state_ff == ST_AP_SAT))
      else $error("allpass products did not end after the last coefficient bit");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("response loaded outside the final step");
`endif

endmodule
